### design/hsvrgb_pkg.sv
// shared constants, stage payload types and sector codes for the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int CB             = COMPONENT_BITS;
  localparam int PACKED_W       = 3 * CB;
  localparam int TDATA_W        = ((PACKED_W + 7) / 8) * 8;

  // one full turn / unity fraction, one bit above the component
  localparam logic [CB:0] CB_ONE = {1'b1, {CB{1'b0}}};

  // color wheel sector, hue * 6 above the fraction bits
  typedef enum logic [2:0] {
    SECT_RED_YELLOW   = 3'd0,
    SECT_YELLOW_GREEN = 3'd1,
    SECT_GREEN_CYAN   = 3'd2,
    SECT_CYAN_BLUE    = 3'd3,
    SECT_BLUE_MAGENTA = 3'd4,
    SECT_MAGENTA_RED  = 3'd5
  } hue_sector_t;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } hsv_pixel_t;

  typedef struct packed {
    hue_sector_t   sector;
    logic [CB-1:0] frac;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } hue_split_t;

  typedef struct packed {
    hue_sector_t   sector;
    logic [CB-1:0] sat_frac;
    logic [CB-1:0] sat_cofrac;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } sat_terms_t;

  typedef struct packed {
    hue_sector_t   sector;
    logic [CB-1:0] val;
    logic [CB-1:0] p_term;
    logic [CB-1:0] q_term;
    logic [CB-1:0] t_term;
  } rgb_terms_t;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_pixel_t;

endpackage

### design/hsvrgb_sector.sv
// stage 1: hue times six, split into sector and fraction
`timescale 1ns / 1ps

module hsvrgb_sector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsvrgb_pkg::hsv_pixel_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsvrgb_pkg::hue_split_t out_data
);
  import hsvrgb_pkg::*;

  logic [CB+2:0] hue_x6;
  logic          valid;
  hue_split_t    data;

  assign hue_x6   = {1'b0, in_data.hue, 2'b00} + {2'b00, in_data.hue, 1'b0};
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data.sector <= hue_sector_t'(hue_x6[CB+2:CB]);
      data.frac   <= hue_x6[CB-1:0];
      data.sat    <= in_data.sat;
      data.val    <= in_data.val;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/hsvrgb_sat_mul.sv
// stage 2: saturation scaled by the hue fraction and by its complement
`timescale 1ns / 1ps

module hsvrgb_sat_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsvrgb_pkg::hue_split_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsvrgb_pkg::sat_terms_t out_data
);
  import hsvrgb_pkg::*;

  logic [CB:0]     one_minus_f;
  logic [2*CB-1:0] prod_sf;
  logic [2*CB:0]   prod_sfc;
  logic            valid;
  sat_terms_t      data;

  assign one_minus_f = CB_ONE - {1'b0, in_data.frac};
  assign prod_sf     = (2*CB)'(in_data.sat) * (2*CB)'(in_data.frac);
  assign prod_sfc    = (2*CB+1)'(in_data.sat) * (2*CB+1)'(one_minus_f);
  assign in_ready    = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // sat < one, so both truncated products stay below one
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data.sector     <= in_data.sector;
      data.sat_frac   <= prod_sf[2*CB-1:CB];
      data.sat_cofrac <= prod_sfc[2*CB-1:CB];
      data.sat        <= in_data.sat;
      data.val        <= in_data.val;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/hsvrgb_val_mul.sv
// stage 3: value scaled into the p, q and t terms
`timescale 1ns / 1ps

module hsvrgb_val_mul (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsvrgb_pkg::sat_terms_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsvrgb_pkg::rgb_terms_t out_data
);
  import hsvrgb_pkg::*;

  logic [CB:0]   k_p;
  logic [CB:0]   k_q;
  logic [CB:0]   k_t;
  logic [2*CB:0] prod_p;
  logic [2*CB:0] prod_q;
  logic [2*CB:0] prod_t;
  logic          valid;
  rgb_terms_t    data;

  assign k_p    = CB_ONE - {1'b0, in_data.sat};
  assign k_q    = CB_ONE - {1'b0, in_data.sat_frac};
  assign k_t    = CB_ONE - {1'b0, in_data.sat_cofrac};
  assign prod_p = (2*CB+1)'(in_data.val) * (2*CB+1)'(k_p);
  assign prod_q = (2*CB+1)'(in_data.val) * (2*CB+1)'(k_q);
  assign prod_t = (2*CB+1)'(in_data.val) * (2*CB+1)'(k_t);

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // zero saturation makes every factor one, so all terms fall back to value
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data.sector <= in_data.sector;
      data.val    <= in_data.val;
      data.p_term <= prod_p[2*CB-1:CB];
      data.q_term <= prod_q[2*CB-1:CB];
      data.t_term <= prod_t[2*CB-1:CB];
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/hsvrgb_select.sv
// stage 4: sector routes terms onto red, green and blue; output register
`timescale 1ns / 1ps

module hsvrgb_select (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsvrgb_pkg::rgb_terms_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsvrgb_pkg::rgb_pixel_t out_data
);
  import hsvrgb_pkg::*;

  rgb_pixel_t rgb_next;
  logic       valid;
  rgb_pixel_t data;

  always_comb begin
    unique case (in_data.sector)
      SECT_RED_YELLOW: begin
        rgb_next = '{red: in_data.val, green: in_data.t_term, blue: in_data.p_term};
      end
      SECT_YELLOW_GREEN: begin
        rgb_next = '{red: in_data.q_term, green: in_data.val, blue: in_data.p_term};
      end
      SECT_GREEN_CYAN: begin
        rgb_next = '{red: in_data.p_term, green: in_data.val, blue: in_data.t_term};
      end
      SECT_CYAN_BLUE: begin
        rgb_next = '{red: in_data.p_term, green: in_data.q_term, blue: in_data.val};
      end
      SECT_BLUE_MAGENTA: begin
        rgb_next = '{red: in_data.t_term, green: in_data.p_term, blue: in_data.val};
      end
      default: begin
        rgb_next = '{red: in_data.val, green: in_data.p_term, blue: in_data.q_term};
      end
    endcase
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= rgb_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

### design/hsv_to_rgb_converter_core.sv
// top level: four-stage hsv to rgb conversion pipeline with stream ports
`timescale 1ns / 1ps

// Converts one pixel per clock from hue/saturation/value to red/green/blue,
// all unsigned fractions of COMPONENT_BITS bits with a binary-angle hue.
// An input transfer passes through four register stages on its way out: hue
// split, saturation products, value products, and sector routing into the
// output register. Throughput is one transfer per clock whenever the output
// side is ready. Each stage holds its own valid bit and stalls only when full
// and blocked downstream, so input transfers keep being taken while a result
// waits, until all stages are full.
module hsv_to_rgb_converter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // hue_angle, saturation_level, brightness_value
  input  logic [hsvrgb_pkg::TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red_level, green_level, blue_level
  output logic [hsvrgb_pkg::TDATA_W-1:0]   m_axis_tdata
);
  import hsvrgb_pkg::*;

  hsv_pixel_t pix_in;
  hue_split_t split_data;
  sat_terms_t sat_data;
  rgb_terms_t terms_data;
  rgb_pixel_t pix_out;

  logic split_valid;
  logic split_ready;
  logic sat_valid;
  logic sat_ready;
  logic terms_valid;
  logic terms_ready;

  assign pix_in.hue = s_axis_tdata[CB-1:0];
  assign pix_in.sat = s_axis_tdata[2*CB-1:CB];
  assign pix_in.val = s_axis_tdata[3*CB-1:2*CB];

  hsvrgb_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (pix_in),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  hsvrgb_sat_mul u_sat_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (sat_valid),
    .out_ready (sat_ready),
    .out_data  (sat_data)
  );

  hsvrgb_val_mul u_val_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sat_valid),
    .in_ready  (sat_ready),
    .in_data   (sat_data),
    .out_valid (terms_valid),
    .out_ready (terms_ready),
    .out_data  (terms_data)
  );

  hsvrgb_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_data   (terms_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (pix_out)
  );

  assign m_axis_tdata = TDATA_W'({pix_out.blue, pix_out.green, pix_out.red});

endmodule

### design/hsvrgb_checker.sv
// port-level checks for the hsv to rgb converter, bound to the top level
`timescale 1ns / 1ps

module hsvrgb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [hsvrgb_pkg::TDATA_W-1:0] m_axis_tdata
);
  import hsvrgb_pkg::*;

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // the input side only backs up when every stage is full and output is blocked
  a_backpressure_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // a blocked result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a blocked result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (.*);
